// ----- rtl/pid_pkg.sv -----
// ----------------------------------------------------------------------------
// pid_pkg: shared definitions of the pid controller
// default data format, configuration register indexes, mode and direction codes and request opcodes
// ----------------------------------------------------------------------------
package pid_pkg;

  // default fixed point format, signed q16.16
  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int GAIN_W      = 31;

  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE_SELECT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION   = 3'd6;

  // request opcodes
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // mode_select codes
  localparam logic MODE_P_ON_ERROR = 1'b0;
  localparam logic MODE_P_ON_MEAS  = 1'b1;

  // direction codes
  localparam logic DIR_DIRECT  = 1'b0;
  localparam logic DIR_REVERSE = 1'b1;

endpackage

// ----- rtl/pid_controller_ponm_antiwindup.sv -----
// ----------------------------------------------------------------------------
// pid_controller_ponm_antiwindup: fixed point pid with selectable p-on-measurement
// derivative on measurement, conditional integration and clamped drive output
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready) carries one request: opcode, measured
//   and setpoint. opcode compute runs one control step, opcode clear zeroes
//   the integral and the last drive and returns drive 0 (last measurement is
//   kept for the derivative).
//   output channel (out_valid / out_ready) returns exactly one drive value
//   per request, in request order.
//   configuration is a plain write port (cfg_write, cfg_index, cfg_data),
//   written only while no request is in flight; index 7 is ignored.
// timing
//   a request accepted into the input register moves to the output register
//   once free. one request per cycle is sustained while the receiver takes
//   results; the input register feeds a single combinational pass (three gain
//   multiplies, integral update and two clamps) into the output register.
// reset and stall
//   rst (synchronous) empties both stages, zeroes the integral, last drive and
//   last measurement, and restores gains 0, full-range limits, p-on-error,
//   direct action. when the receiver stalls the result holds in the output
//   register; the input register may still take one more request behind it.
// ----------------------------------------------------------------------------
module pid_controller_ponm_antiwindup #(
  parameter int FRAC_BITS  = pid_pkg::DEF_FRAC_BITS,
  parameter int DATA_WIDTH = pid_pkg::DEF_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [pid_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pid_pkg::CFG_DATA_W-1:0]      cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic signed [31:0]                  measured,
  input  logic signed [31:0]                  setpoint,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  drive
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int GW = pid_pkg::GAIN_W;
  // width that holds any 32-bit input and any data word with sign
  localparam int EW = ((DW > 32) ? DW : 32) + 1;
  // headroom for up to three data words summed before a clamp
  localparam int SW = DW + 3;
  // gain times a 64-bit padded magnitude, split at bit 32
  localparam int PW = GW + 64;

  localparam logic signed [DW-1:0] DMAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN  = {1'b1, {(DW-1){1'b0}}};
  localparam logic        [DW-1:0] DMAXU = {1'b0, {(DW-1){1'b1}}};

  // 32-bit word, sign extended and saturated to the data range
  function automatic logic signed [DW-1:0] sat_in32(input logic [31:0] v);
    logic signed [EW-1:0] x;
    logic signed [DW-1:0] r;
    x = EW'(signed'(v));
    if (x > EW'(DMAX)) begin
      r = DMAX;
    end else if (x < EW'(DMIN)) begin
      r = DMIN;
    end else begin
      r = DW'(x);
    end
    return r;
  endfunction

  // difference saturated back to the data range
  function automatic logic signed [DW-1:0] sat_diff(input logic signed [DW:0] v);
    logic signed [DW-1:0] r;
    if (v > (DW+1)'(DMAX)) begin
      r = DMAX;
    end else if (v < (DW+1)'(DMIN)) begin
      r = DMIN;
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  // sign-magnitude gain product, truncated toward zero, saturated magnitude
  function automatic logic signed [DW-1:0] gmul(input logic [GW-1:0] g,
                                                 input logic signed [DW-1:0] x,
                                                 input logic rev);
    logic          neg;
    logic [DW-1:0] mag;
    logic [63:0]   mag64;
    logic [62:0]   plo;
    logic [62:0]   phi;
    logic [PW-1:0] prod;
    logic [PW-1:0] q;
    logic [DW-1:0] m;
    neg   = x[DW-1];
    mag   = neg ? (~unsigned'(x) + DW'(1)) : unsigned'(x);
    mag64 = 64'(mag);
    plo   = 63'(g) * 63'(mag64[31:0]);
    phi   = 63'(g) * 63'(mag64[63:32]);
    prod  = {phi, 32'b0} + PW'(plo);
    q     = prod >> FB;
    m     = (q > PW'(DMAXU)) ? DMAXU : q[DW-1:0];
    neg   = neg ^ rev;
    return neg ? signed'(DW'(0) - m) : signed'(m);
  endfunction

  // clamp, high limit checked first
  function automatic logic signed [DW-1:0] clamp_lim(input logic signed [SW-1:0] v,
                                                      input logic signed [DW-1:0] lo,
                                                      input logic signed [DW-1:0] hi);
    logic signed [DW-1:0] r;
    if (v > SW'(hi)) begin
      r = hi;
    end else if (v < SW'(lo)) begin
      r = lo;
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  // configuration registers
  logic [GW-1:0]        prop_gain;
  logic [GW-1:0]        integ_gain;
  logic [GW-1:0]        deriv_gain;
  logic signed [DW-1:0] drive_low_limit;
  logic signed [DW-1:0] drive_high_limit;
  logic                 mode_select;
  logic                 direction;

  // controller state
  logic signed [DW-1:0] integral_sum;
  logic signed [DW-1:0] prev_measured;
  logic signed [DW-1:0] prev_drive;

  // input register
  logic                 s1_valid;
  logic                 s1_opcode;
  logic signed [31:0]   s1_measured;
  logic signed [31:0]   s1_setpoint;

  logic                 adv;
  logic                 s1_fire;

  // datapath
  logic                 rev_act;
  logic signed [DW-1:0] meas;
  logic signed [DW-1:0] sp;
  logic signed [DW-1:0] perr;
  logic signed [DW-1:0] derr;
  logic signed [DW-1:0] p_in;
  logic signed [DW-1:0] p_term;
  logic signed [DW-1:0] i_term;
  logic signed [DW-1:0] d_term;
  logic signed [SW-1:0] integ_a;
  logic signed [SW-1:0] integ_b;
  logic signed [DW-1:0] integ_c;
  logic signed [SW-1:0] drv_a;
  logic signed [DW-1:0] drv_c;
  logic                 hold_integ;
  logic signed [EW-1:0] drv_ext;

  logic signed [DW-1:0] integral_sum_next;
  logic signed [DW-1:0] prev_measured_next;
  logic signed [DW-1:0] prev_drive_next;
  logic signed [31:0]   drive_next;

  // output register frees when empty or taken; input register moves into it
  assign adv      = !out_valid || out_ready;
  assign s1_fire  = s1_valid && adv;
  assign in_ready = !s1_valid || adv;

  // error and measurement change, both saturated
  assign meas = sat_in32(s1_measured);
  assign sp   = sat_in32(s1_setpoint);
  assign perr = sat_diff((DW+1)'(sp) - (DW+1)'(meas));
  assign derr = sat_diff((DW+1)'(meas) - (DW+1)'(prev_measured));

  // reverse action negates every gain
  assign rev_act = (direction == pid_pkg::DIR_REVERSE);

  // one shared p multiply: on error or on measurement change per mode
  assign p_in   = (mode_select == pid_pkg::MODE_P_ON_MEAS) ? derr : perr;
  assign p_term = gmul(prop_gain, p_in, rev_act);
  assign i_term = gmul(integ_gain, perr, rev_act);
  assign d_term = gmul(deriv_gain, derr, rev_act);

  always_comb begin
    // p-on-measurement moves the p action into the integral
    integ_a = SW'(integral_sum);
    if (mode_select == pid_pkg::MODE_P_ON_MEAS) begin
      integ_a = SW'(integral_sum) - SW'(p_term);
    end

    // anti-windup: stop integrating further into a saturated output
    hold_integ = ((prev_drive >= drive_high_limit) && !perr[DW-1] && !integ_a[SW-1]) ||
                 ((prev_drive < drive_low_limit) && perr[DW-1] && integ_a[SW-1]);

    integ_b = hold_integ ? integ_a : (integ_a + SW'(i_term));
    integ_c = clamp_lim(integ_b, drive_low_limit, drive_high_limit);

    // derivative on measurement, p on error only in the default mode
    drv_a = SW'(integ_c) - SW'(d_term);
    if (mode_select == pid_pkg::MODE_P_ON_ERROR) begin
      drv_a = drv_a + SW'(p_term);
    end
    drv_c   = clamp_lim(drv_a, drive_low_limit, drive_high_limit);
    drv_ext = EW'(drv_c);

    // clear request zeroes integral and drive, keeps the last measurement
    if (s1_opcode == pid_pkg::OP_CLEAR) begin
      integral_sum_next  = '0;
      prev_drive_next    = '0;
      prev_measured_next = prev_measured;
      drive_next         = '0;
    end else begin
      integral_sum_next  = integ_c;
      prev_drive_next    = drv_c;
      prev_measured_next = meas;
      drive_next         = drv_ext[31:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain        <= '0;
      integ_gain       <= '0;
      deriv_gain       <= '0;
      drive_low_limit  <= sat_in32(32'h8000_0000);
      drive_high_limit <= sat_in32(32'h7FFF_FFFF);
      mode_select      <= pid_pkg::MODE_P_ON_ERROR;
      direction        <= pid_pkg::DIR_DIRECT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pid_pkg::REG_PROP_GAIN:   prop_gain        <= cfg_data[GW-1:0];
        pid_pkg::REG_INTEG_GAIN:  integ_gain       <= cfg_data[GW-1:0];
        pid_pkg::REG_DERIV_GAIN:  deriv_gain       <= cfg_data[GW-1:0];
        pid_pkg::REG_LOW_LIMIT:   drive_low_limit  <= sat_in32(cfg_data);
        pid_pkg::REG_HIGH_LIMIT:  drive_high_limit <= sat_in32(cfg_data);
        pid_pkg::REG_MODE_SELECT: mode_select      <= cfg_data[0];
        pid_pkg::REG_DIRECTION:   direction        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode   <= opcode;
      s1_measured <= measured;
      s1_setpoint <= setpoint;
    end
  end

  // controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      integral_sum  <= '0;
      prev_measured <= '0;
      prev_drive    <= '0;
    end else begin
      if (adv) begin
        out_valid <= s1_valid;
      end
      if (s1_fire) begin
        integral_sum  <= integral_sum_next;
        prev_measured <= prev_measured_next;
        prev_drive    <= prev_drive_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      drive <= drive_next;
    end
  end

`ifndef SYNTHESIS
  logic signed [EW-1:0] prev_drive_ext;
  assign prev_drive_ext = EW'(prev_drive);

  // a clear request leaves zero integral and zero drive
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_opcode == pid_pkg::OP_CLEAR) |=>
      (integral_sum == '0 && prev_drive == '0 && drive == '0))
    else $error("clear request did not zero integral and drive");

  // after a compute step the integral sits inside ordered limits
  a_integ_in_limits: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_opcode == pid_pkg::OP_COMPUTE &&
     drive_low_limit <= drive_high_limit) |=>
      (integral_sum >= $past(drive_low_limit) && integral_sum <= $past(drive_high_limit)))
    else $error("integral outside drive limits after compute");

  // the presented result is the drive kept for anti-windup
  a_drive_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive == prev_drive_ext[31:0]))
    else $error("output drive differs from stored last drive");
`endif

endmodule
